// File: rtl/core/dnsrae_pkg.sv
// ----------------------------------------------------------------------------
// dnsrae_pkg
// Shared constants for the DNS reply answer extractor: item kinds, status
// codes, DNS header field codes and size limits.
// ----------------------------------------------------------------------------
package dnsrae_pkg;

    // item kinds on the input channel
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_RESOLVED = 2'd0;
    localparam logic [1:0] ST_NO_DATA  = 2'd1;
    localparam logic [1:0] ST_RCODE    = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    // dns header codes
    localparam logic [3:0] RCODE_NOERROR  = 4'd0;
    localparam logic [3:0] RCODE_NXDOMAIN = 4'd3;
    localparam logic [7:0] QR_MASK        = 8'h80;
    localparam logic [7:0] RCODE_MASK     = 8'h0F;
    localparam logic [7:0] PTR_MASK       = 8'hC0;
    localparam logic [15:0] TYPE_AAAA     = 16'd28;
    localparam logic [15:0] ADDR6_BYTES   = 16'd16;
    localparam logic [15:0] ADDR4_BYTES   = 16'd4;

    // sizes
    localparam int unsigned HEADER_BYTES     = 12;
    localparam int unsigned MAX_REPLY_BYTES_DEF = 512;
    localparam int unsigned LEN_W            = 10;

endpackage

// File: rtl/core/dns_response_answer_extractor.sv
// ----------------------------------------------------------------------------
// dns_response_answer_extractor
// Checks a DNS reply streamed one byte per word and returns the first address
// record of the requested type, or the reason no address was found.
// ----------------------------------------------------------------------------
// A start word loads the query ID, the wanted record type and the reply length
// (lengths above MAX_REPLY_BYTES are cut to it); byte words then carry the reply.
// The parser handles each word in a single pass, updating its counters and
// field registers together; s_ready stays high every cycle except while a
// result sits in the output register with m_ready low. One result word comes
// out the cycle after the last reply byte is taken (or after a start word with
// length zero); byte words that arrive with no reply open are dropped, and a
// start word in mid-reply abandons the old reply without a result.
module dns_response_answer_extractor
    import dnsrae_pkg::*;
#(
    parameter int unsigned MAX_REPLY_BYTES = MAX_REPLY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_query_id,
    input  logic [15:0] s_query_type,
    input  logic [9:0]  s_reply_length,
    input  logic [7:0]  s_reply_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_answer_length,
    output logic [63:0] m_address_high,
    output logic [63:0] m_address_low
);

    localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
    localparam int unsigned CAP_INT = (MAX_REPLY_BYTES > LEN_MAX) ? LEN_MAX : MAX_REPLY_BYTES;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HEADER_BYTES);

    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_QNAME, PH_OWN1, PH_OWNR,
        PH_RHDR, PH_RDATA, PH_DONE, PH_REJECT
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [LEN_W-1:0]   total_len_reg, total_len_next;
    logic [LEN_W-1:0]   field_pos_reg, field_pos_next;
    logic [15:0]        expected_id_reg, expected_id_next;
    logic [15:0]        wanted_type_reg, wanted_type_next;
    logic [15:0]        recv_id_reg, recv_id_next;
    logic [3:0]         rcode_reg, rcode_next;
    logic [15:0]        answers_left_reg, answers_left_next;
    logic [15:0]        rec_type_reg, rec_type_next;
    logic [15:0]        rdlen_reg, rdlen_next;
    logic [127:0]       addr_buf_reg, addr_buf_next;
    logic               found_reg, found_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [4:0]         m_answer_length_reg, m_answer_length_next;
    logic [63:0]        m_address_high_reg, m_address_high_next;
    logic [63:0]        m_address_low_reg, m_address_low_next;

    logic               accept;
    logic [LEN_W-1:0]   len_clamped;
    logic [LEN_W-1:0]   offset;
    logic               past_field;
    logic [7:0]         b;
    logic [15:0]        want_len;
    logic [3:0]         byte_sel;
    logic               jump_en;
    phase_t             jump_ph;
    logic [16:0]        jump_pos;
    logic               ans_start;
    logic [16:0]        ans_pos;
    logic               emit_en;
    logic               emit_ok;
    logic [1:0]         emit_status;

    assign accept      = s_valid & s_ready;
    assign s_ready     = ~m_valid_reg | m_ready;
    assign len_clamped = (s_reply_length > LEN_CAP) ? LEN_CAP : s_reply_length;
    assign offset      = byte_pos_reg - field_pos_reg;
    assign past_field  = byte_pos_reg >= field_pos_reg;
    assign b           = s_reply_byte;
    assign want_len    = (wanted_type_reg == TYPE_AAAA) ? ADDR6_BYTES : ADDR4_BYTES;
    assign byte_sel    = 4'd15 - offset[3:0];

    always_comb begin
        phase_next        = phase_reg;
        byte_pos_next     = byte_pos_reg;
        total_len_next    = total_len_reg;
        field_pos_next    = field_pos_reg;
        expected_id_next  = expected_id_reg;
        wanted_type_next  = wanted_type_reg;
        recv_id_next      = recv_id_reg;
        rcode_next        = rcode_reg;
        answers_left_next = answers_left_reg;
        rec_type_next     = rec_type_reg;
        rdlen_next        = rdlen_reg;
        addr_buf_next     = addr_buf_reg;
        found_next        = found_reg;
        jump_en           = 1'b0;
        jump_ph           = PH_DONE;
        jump_pos          = '0;
        ans_start         = 1'b0;
        ans_pos           = '0;
        emit_en           = 1'b0;
        emit_ok           = 1'b0;
        emit_status       = ST_REJECT;

        if (accept && s_kind == KIND_START) begin
            byte_pos_next     = '0;
            field_pos_next    = '0;
            recv_id_next      = '0;
            rcode_next        = '0;
            answers_left_next = '0;
            rec_type_next     = '0;
            rdlen_next        = '0;
            addr_buf_next     = '0;
            found_next        = 1'b0;
            expected_id_next  = s_query_id;
            wanted_type_next  = s_query_type;
            total_len_next    = len_clamped;
            if (len_clamped == '0) begin
                phase_next  = PH_IDLE;
                emit_en     = 1'b1;
                emit_status = ST_REJECT;
            end else begin
                phase_next = PH_HDR;
            end
        end else if (accept && phase_reg != PH_IDLE) begin
            case (phase_reg)
                PH_HDR: begin
                    case (byte_pos_reg)
                        10'd0:  recv_id_next = {b, 8'h00};
                        10'd1:  recv_id_next = {recv_id_reg[15:8], b};
                        10'd2:  if ((b & QR_MASK) == 8'h00) phase_next = PH_REJECT;
                        10'd3:  rcode_next = 4'(b & RCODE_MASK);
                        10'd6:  answers_left_next = {b, 8'h00};
                        10'd7:  answers_left_next = {answers_left_reg[15:8], b};
                        10'd11: begin
                            if (recv_id_reg != expected_id_reg) begin
                                phase_next = PH_REJECT;
                            end else if (rcode_reg != RCODE_NOERROR) begin
                                phase_next = PH_DONE;
                            end else begin
                                jump_en  = 1'b1;
                                jump_ph  = PH_QNAME;
                                jump_pos = 17'(HEADER_BYTES);
                            end
                        end
                        default: ;
                    endcase
                end
                PH_QNAME: begin
                    if (byte_pos_reg == field_pos_reg) begin
                        if (b == 8'h00) begin
                            ans_start = 1'b1;
                            ans_pos   = 17'(byte_pos_reg) + 17'd5;
                        end else if ((b & PTR_MASK) == PTR_MASK) begin
                            ans_start = 1'b1;
                            ans_pos   = 17'(byte_pos_reg) + 17'd6;
                        end else begin
                            jump_en  = 1'b1;
                            jump_ph  = PH_QNAME;
                            jump_pos = 17'(byte_pos_reg) + 17'd1 + 17'(b);
                        end
                    end
                end
                PH_OWN1: begin
                    if (byte_pos_reg == field_pos_reg) begin
                        jump_en = 1'b1;
                        if ((b & PTR_MASK) == PTR_MASK) begin
                            jump_ph  = PH_RHDR;
                            jump_pos = 17'(byte_pos_reg) + 17'd2;
                        end else if (b == 8'h00) begin
                            jump_ph  = PH_RHDR;
                            jump_pos = 17'(byte_pos_reg) + 17'd1;
                        end else begin
                            jump_ph  = PH_OWNR;
                            jump_pos = 17'(byte_pos_reg) + 17'd1 + 17'(b);
                        end
                    end
                end
                PH_OWNR: begin
                    if (byte_pos_reg == field_pos_reg) begin
                        jump_en = 1'b1;
                        if (b == 8'h00) begin
                            jump_ph  = PH_RHDR;
                            jump_pos = 17'(byte_pos_reg) + 17'd1;
                        end else begin
                            jump_ph  = PH_OWNR;
                            jump_pos = 17'(byte_pos_reg) + 17'd1 + 17'(b);
                        end
                    end
                end
                PH_RHDR: begin
                    if (past_field) begin
                        case (offset)
                            10'd0: rec_type_next = {b, 8'h00};
                            10'd1: rec_type_next = {rec_type_reg[15:8], b};
                            10'd8: rdlen_next = {b, 8'h00};
                            10'd9: begin
                                rdlen_next = {rdlen_reg[15:8], b};
                                if (rec_type_reg == wanted_type_reg
                                        && {rdlen_reg[15:8], b} == want_len) begin
                                    addr_buf_next = '0;
                                    jump_en  = 1'b1;
                                    jump_ph  = PH_RDATA;
                                    jump_pos = 17'(byte_pos_reg) + 17'd1;
                                end else begin
                                    answers_left_next = answers_left_reg - 16'd1;
                                    ans_start = 1'b1;
                                    ans_pos   = 17'(byte_pos_reg) + 17'd1
                                              + 17'({rdlen_reg[15:8], b});
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                PH_RDATA: begin
                    if (past_field) begin
                        if (offset < 10'd16) begin
                            addr_buf_next[{byte_sel, 3'b000} +: 8] = b;
                        end
                        if (17'(offset) + 17'd1 >= 17'(rdlen_reg)) begin
                            found_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                end
                default: ;
            endcase

            // next answer record, if any are left
            if (ans_start) begin
                if (answers_left_next == 16'd0) begin
                    phase_next = PH_DONE;
                end else begin
                    jump_en  = 1'b1;
                    jump_ph  = PH_OWN1;
                    jump_pos = ans_pos;
                end
            end
            // a field that starts past the reply ends parsing
            if (jump_en) begin
                if (jump_pos >= 17'(total_len_reg)) begin
                    phase_next = PH_DONE;
                end else begin
                    phase_next     = jump_ph;
                    field_pos_next = jump_pos[LEN_W-1:0];
                end
            end

            byte_pos_next = byte_pos_reg + 10'd1;
            if (byte_pos_next >= total_len_reg) begin
                emit_en = 1'b1;
                if (total_len_reg < HDR_LEN || phase_next == PH_REJECT) begin
                    emit_status = ST_REJECT;
                end else if (rcode_next == RCODE_NXDOMAIN) begin
                    emit_status = ST_NO_DATA;
                end else if (rcode_next == RCODE_NOERROR) begin
                    emit_ok     = found_next;
                    emit_status = found_next ? ST_RESOLVED : ST_NO_DATA;
                end else begin
                    emit_status = ST_RCODE;
                end
                phase_next = PH_IDLE;
            end
        end
    end

    always_comb begin
        m_valid_next         = m_valid_reg;
        m_status_next        = m_status_reg;
        m_answer_length_next = m_answer_length_reg;
        m_address_high_next  = m_address_high_reg;
        m_address_low_next   = m_address_low_reg;
        if (emit_en) begin
            m_valid_next         = 1'b1;
            m_status_next        = emit_status;
            m_answer_length_next = emit_ok ? rdlen_next[4:0] : 5'd0;
            m_address_high_next  = emit_ok ? addr_buf_next[127:64] : 64'd0;
            m_address_low_next   = emit_ok ? addr_buf_next[63:0] : 64'd0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            byte_pos_reg     <= '0;
            total_len_reg    <= '0;
            field_pos_reg    <= '0;
            expected_id_reg  <= '0;
            wanted_type_reg  <= '0;
            recv_id_reg      <= '0;
            rcode_reg        <= '0;
            answers_left_reg <= '0;
            rec_type_reg     <= '0;
            rdlen_reg        <= '0;
            addr_buf_reg     <= '0;
            found_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            byte_pos_reg     <= byte_pos_next;
            total_len_reg    <= total_len_next;
            field_pos_reg    <= field_pos_next;
            expected_id_reg  <= expected_id_next;
            wanted_type_reg  <= wanted_type_next;
            recv_id_reg      <= recv_id_next;
            rcode_reg        <= rcode_next;
            answers_left_reg <= answers_left_next;
            rec_type_reg     <= rec_type_next;
            rdlen_reg        <= rdlen_next;
            addr_buf_reg     <= addr_buf_next;
            found_reg        <= found_next;
            m_valid_reg      <= m_valid_next;
        end
        m_status_reg        <= m_status_next;
        m_answer_length_reg <= m_answer_length_next;
        m_address_high_reg  <= m_address_high_next;
        m_address_low_reg   <= m_address_low_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_answer_length = m_answer_length_reg;
    assign m_address_high  = m_address_high_reg;
    assign m_address_low   = m_address_low_reg;

`ifndef SYNTHESIS
    // only a resolved result carries address data
    a_unresolved_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_RESOLVED
            |-> m_answer_length == 5'd0 && m_address_high == 64'd0
                && m_address_low == 64'd0)
        else $error("unresolved result carries address data");

    // a resolved result is a v4 or v6 address
    a_resolved_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_RESOLVED
            |-> (m_answer_length == 5'd16)
                || (m_answer_length == 5'd4 && m_address_low == 64'd0
                    && m_address_high[31:0] == 32'd0))
        else $error("resolved result has bad address length");

    // an empty reply is rejected on the next cycle
    a_empty_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_START && s_reply_length == 10'd0
            |=> m_valid && m_status == ST_REJECT)
        else $error("empty reply not rejected");

    // capture only runs on a matching record that is not yet found
    a_rdata_unfound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RDATA |-> !found_reg && rec_type_reg == wanted_type_reg)
        else $error("address capture in wrong context");
`endif

endmodule

// File: bench/dns_response_answer_extractor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_response_answer_extractor_test
// Streams DNS replies into the extractor and checks every result word against
// a cycle-free model of the parser: header checks, rcodes, question skipping,
// answer walking and address capture, length limits and restarts, followed by
// randomized replies under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module dns_response_answer_extractor_test;
    import dnsrae_pkg::*;

    localparam int unsigned REPLY_CAP          = MAX_REPLY_BYTES_DEF;
    localparam int unsigned QUIET_LIMIT        = 2000;
    localparam int unsigned RANDOM_WORDS       = 320;
    localparam int unsigned CALM_WORDS         = 120;

    typedef enum logic [3:0] {
        P_IDLE, P_HEADER, P_QNAME, P_OWNER_FIRST, P_OWNER_REST,
        P_REC_HEADER, P_REC_DATA, P_DONE, P_REJECT
    } parse_phase_t;

    typedef enum int {NAME_PTR, NAME_ROOT, NAME_LABELS} name_style_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  alen;
        logic [63:0] hi;
        logic [63:0] lo;
    } answer_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_kind         = KIND_START;
    logic [15:0] s_query_id     = '0;
    logic [15:0] s_query_type   = '0;
    logic [9:0]  s_reply_length = '0;
    logic [7:0]  s_reply_byte   = '0;
    logic        m_ready        = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [1:0]  m_status;
    logic [4:0]  m_answer_length;
    logic [63:0] m_address_high;
    logic [63:0] m_address_low;

    dns_response_answer_extractor #(
        .MAX_REPLY_BYTES(REPLY_CAP)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_query_id     (s_query_id),
        .s_query_type   (s_query_type),
        .s_reply_length (s_reply_length),
        .s_reply_byte   (s_reply_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_answer_length(m_answer_length),
        .m_address_high (m_address_high),
        .m_address_low  (m_address_low)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    int          idle_pct       = 16;
    int unsigned quiet_cycles   = 0;
    int unsigned words_sent     = 0;
    int unsigned replies_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned aaaa_seen      = 0;
    int unsigned mismatch_count = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};

    answer_t    expected_answers[$];
    logic [7:0] reply_buf[$];

    // parser state as the block should hold it
    parse_phase_t ph = P_IDLE;
    int unsigned  byte_idx, reply_len, field_pos;
    logic [15:0]  want_id, want_type, got_id, answers_left, rec_type, rec_len;
    logic [3:0]   rcode;
    logic [63:0]  addr_hi, addr_lo;
    bit           have_answer;

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void clear_reply();
        byte_idx     = 0;
        field_pos    = 0;
        got_id       = '0;
        rcode        = '0;
        answers_left = '0;
        rec_type     = '0;
        rec_len      = '0;
        addr_hi      = '0;
        addr_lo      = '0;
        have_answer  = 1'b0;
    endfunction

    function automatic void advance_to(parse_phase_t nxt, int unsigned q);
        if (q >= reply_len) begin
            ph = P_DONE;
        end else begin
            ph        = nxt;
            field_pos = q;
        end
    endfunction

    function automatic void next_answer(int unsigned q);
        if (answers_left == 0)
            ph = P_DONE;
        else
            advance_to(P_OWNER_FIRST, q);
    endfunction

    function automatic void parse_byte(int unsigned pos, logic [7:0] data);
        int unsigned off;
        case (ph)
            P_HEADER: begin
                case (pos)
                    0: got_id = {data, 8'h00};
                    1: got_id[7:0] = data;
                    2: if ((data & QR_MASK) == 8'h00) ph = P_REJECT;
                    3: rcode = data[3:0] & RCODE_MASK[3:0];
                    6: answers_left = {data, 8'h00};
                    7: answers_left[7:0] = data;
                    11: begin
                        if (got_id != want_id)
                            ph = P_REJECT;
                        else if (rcode != RCODE_NOERROR)
                            ph = P_DONE;
                        else
                            advance_to(P_QNAME, HEADER_BYTES);
                    end
                    default: ;
                endcase
            end
            P_QNAME: begin
                if (pos == field_pos) begin
                    // terminator or pointer, then qtype and qclass
                    if (data == 8'h00)
                        next_answer(pos + 5);
                    else if ((data & PTR_MASK) == PTR_MASK)
                        next_answer(pos + 6);
                    else
                        advance_to(P_QNAME, pos + 1 + data);
                end
            end
            P_OWNER_FIRST: begin
                if (pos == field_pos) begin
                    if ((data & PTR_MASK) == PTR_MASK)
                        advance_to(P_REC_HEADER, pos + 2);
                    else if (data == 8'h00)
                        advance_to(P_REC_HEADER, pos + 1);
                    else
                        advance_to(P_OWNER_REST, pos + 1 + data);
                end
            end
            P_OWNER_REST: begin
                if (pos == field_pos) begin
                    if (data == 8'h00)
                        advance_to(P_REC_HEADER, pos + 1);
                    else
                        advance_to(P_OWNER_REST, pos + 1 + data);
                end
            end
            P_REC_HEADER: begin
                if (pos >= field_pos) begin
                    off = pos - field_pos;
                    case (off)
                        0: rec_type = {data, 8'h00};
                        1: rec_type[7:0] = data;
                        8: rec_len = {data, 8'h00};
                        9: begin
                            rec_len[7:0] = data;
                            if (rec_type == want_type && rec_len ==
                                    ((want_type == TYPE_AAAA) ? ADDR6_BYTES : ADDR4_BYTES)) begin
                                addr_hi = '0;
                                addr_lo = '0;
                                advance_to(P_REC_DATA, pos + 1);
                            end else begin
                                answers_left = answers_left - 16'd1;
                                next_answer(pos + 1 + rec_len);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            P_REC_DATA: begin
                if (pos >= field_pos) begin
                    off = pos - field_pos;
                    if (off < 8)
                        addr_hi |= 64'(data) << (56 - 8 * off);
                    else if (off < 16)
                        addr_lo |= 64'(data) << (56 - 8 * (off - 8));
                    if (off + 1 >= rec_len) begin
                        have_answer = 1'b1;
                        ph          = P_DONE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic answer_t reply_outcome();
        answer_t a;
        a = '0;
        if (reply_len < HEADER_BYTES || ph == P_REJECT) begin
            a.status = ST_REJECT;
        end else if (rcode == RCODE_NXDOMAIN) begin
            a.status = ST_NO_DATA;
        end else if (rcode != RCODE_NOERROR) begin
            a.status = ST_RCODE;
        end else if (!have_answer) begin
            a.status = ST_NO_DATA;
        end else begin
            a.status = ST_RESOLVED;
            a.alen   = rec_len[4:0];
            a.hi     = addr_hi;
            a.lo     = addr_lo;
        end
        return a;
    endfunction

    function automatic void predict_word(logic kind, logic [15:0] qid, logic [15:0] qtype,
                                         logic [9:0] len, logic [7:0] data);
        answer_t a;
        if (kind == KIND_START) begin
            clear_reply();
            want_id   = qid;
            want_type = qtype;
            reply_len = (len > REPLY_CAP) ? REPLY_CAP : len;
            if (reply_len == 0) begin
                a        = '0;
                a.status = ST_REJECT;
                expected_answers.push_back(a);
                ph = P_IDLE;
            end else begin
                ph = P_HEADER;
            end
        end else if (ph != P_IDLE) begin
            parse_byte(byte_idx, data);
            byte_idx = (byte_idx + 1) % 1024;
            if (byte_idx >= reply_len) begin
                expected_answers.push_back(reply_outcome());
                ph = P_IDLE;
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin : check_answers
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch($sformatf("result word with none expected, status %0d",
                                          m_status));
            end else begin
                want = expected_answers.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, want.status));
                if (m_answer_length !== want.alen)
                    report_mismatch($sformatf("answer_length %0d, expected %0d",
                                              m_answer_length, want.alen));
                if (m_address_high !== want.hi)
                    report_mismatch($sformatf("address_high %h, expected %h",
                                              m_address_high, want.hi));
                if (m_address_low !== want.lo)
                    report_mismatch($sformatf("address_low %h, expected %h",
                                              m_address_low, want.lo));
                results_seen++;
                status_seen[want.status]++;
                if (want.status == ST_RESOLVED && want.alen == 5'(ADDR6_BYTES))
                    aaaa_seen++;
            end
        end
    end

    always @(posedge aclk)
        m_ready <= !chance(idle_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("timeout: %0d cycles without a word moving", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ---- reply building ----

    function automatic void put_random(int unsigned n);
        repeat (n) reply_buf.push_back(8'($urandom));
    endfunction

    function automatic void put_header(logic [15:0] id, logic [7:0] flags,
                                       logic [7:0] rc_byte, logic [15:0] ancount);
        reply_buf.push_back(id[15:8]);
        reply_buf.push_back(id[7:0]);
        reply_buf.push_back(flags);
        reply_buf.push_back(rc_byte);
        reply_buf.push_back(8'h00);
        reply_buf.push_back(8'h01);
        reply_buf.push_back(ancount[15:8]);
        reply_buf.push_back(ancount[7:0]);
        put_random(4);
    endfunction

    function automatic void put_name(name_style_t style);
        int unsigned len;
        case (style)
            NAME_PTR: begin
                reply_buf.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
                reply_buf.push_back(8'($urandom));
            end
            NAME_ROOT: reply_buf.push_back(8'h00);
            default: begin
                repeat ($urandom_range(1, 3)) begin
                    len = $urandom_range(1, 6);
                    reply_buf.push_back(8'(len));
                    put_random(len);
                end
                reply_buf.push_back(8'h00);
            end
        endcase
    endfunction

    function automatic void put_question(name_style_t style);
        put_name(style);
        put_random(4);
    endfunction

    function automatic void put_record(name_style_t style, logic [15:0] rtype,
                                       logic [15:0] rdlen);
        put_name(style);
        reply_buf.push_back(rtype[15:8]);
        reply_buf.push_back(rtype[7:0]);
        put_random(6);
        reply_buf.push_back(rdlen[15:8]);
        reply_buf.push_back(rdlen[7:0]);
        put_random(rdlen);
    endfunction

    // ---- stimulus ----

    task automatic send_word(logic kind, logic [15:0] qid, logic [15:0] qtype,
                             logic [9:0] len, logic [7:0] data);
        while (chance(idle_pct)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_query_id     <= qid;
        s_query_type   <= qtype;
        s_reply_length <= len;
        s_reply_byte   <= data;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_word(kind, qid, qtype, len, data);
        words_sent++;
    endtask

    task automatic send_stray(int unsigned n);
        repeat (n)
            send_word(KIND_BYTE, 16'($urandom), 16'($urandom), 10'($urandom), 8'($urandom));
    endtask

    // declared length and number of byte words are independent of the built reply
    task automatic send_reply(logic [15:0] id, logic [15:0] want, int unsigned declared,
                              int unsigned count);
        if (count > reply_buf.size())
            put_random(count - reply_buf.size());
        send_word(KIND_START, id, want, 10'(declared), 8'($urandom));
        for (int unsigned i = 0; i < count; i++)
            send_word(KIND_BYTE, 16'($urandom), 16'($urandom), 10'($urandom), reply_buf[i]);
        reply_buf.delete();
        replies_sent++;
    endtask

    task automatic send_built(logic [15:0] id, logic [15:0] want);
        send_reply(id, want, reply_buf.size(), reply_buf.size());
    endtask

    task automatic test_short_replies();
        send_reply(16'h0000, 16'h0000, 0, 0);
        send_stray(2);
        put_header(16'h0102, 8'h80, 8'h00, 16'd1);
        send_reply(16'h0102, 16'd1, HEADER_BYTES - 1, HEADER_BYTES - 1);
        send_reply(16'hFFFF, 16'hFFFF, 1, 1);
        send_stray(1);
    endtask

    task automatic test_header_checks();
        put_header(16'h1234, 8'h81, 8'h80, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_built(16'h1235, 16'd1);
        // qr clear
        put_header(16'h4321, 8'h7F, 8'h00, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_built(16'h4321, 16'd1);
        // nxdomain with the upper flag bits set
        put_header(16'h5555, 8'h85, 8'hF3, 16'd0);
        put_question(NAME_PTR);
        send_built(16'h5555, 16'd1);
        put_header(16'hAAAA, 8'hFF, 8'h0F, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_built(16'hAAAA, 16'd1);
        put_header(16'h0001, 8'h80, 8'h02, 16'd0);
        send_built(16'h0001, 16'd1);
        // noerror but the question lies past the end
        put_header(16'h0F0F, 8'h80, 8'h00, 16'd3);
        send_built(16'h0F0F, 16'd1);
    endtask

    task automatic test_address_records();
        int unsigned n;
        put_header(16'hFFFF, 8'h80, 8'h00, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_built(16'hFFFF, 16'd1);
        put_header(16'h6001, 8'h84, 8'h00, 16'd1);
        put_question(NAME_PTR);
        put_record(NAME_LABELS, TYPE_AAAA, ADDR6_BYTES);
        send_built(16'h6001, TYPE_AAAA);
        // skip a cname, then a root-owned match
        put_header(16'h6002, 8'h80, 8'h00, 16'd2);
        put_question(NAME_PTR);
        put_record(NAME_PTR, 16'd5, 16'd7);
        put_record(NAME_ROOT, 16'd1, ADDR4_BYTES);
        send_built(16'h6002, 16'd1);
        // right type, wrong rdlength
        put_header(16'h6003, 8'h80, 8'h00, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, TYPE_AAAA, ADDR4_BYTES);
        send_built(16'h6003, TYPE_AAAA);
        // ancount runs out before the match
        put_header(16'h6004, 8'h80, 8'h00, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, 16'd5, 16'd3);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_built(16'h6004, 16'd1);
        put_header(16'h6005, 8'h80, 8'h00, 16'd0);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_built(16'h6005, 16'd1);
        put_header(16'h6006, 8'h80, 8'h00, 16'd1);
        put_question(NAME_ROOT);
        put_record(NAME_PTR, 16'hFFFF, ADDR4_BYTES);
        send_built(16'h6006, 16'hFFFF);
        // rdata cut off by the declared length
        put_header(16'h6007, 8'h80, 8'h00, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        n = reply_buf.size();
        send_reply(16'h6007, 16'd1, n - 2, n);
    endtask

    task automatic test_length_limits();
        int unsigned filler;
        // declared length over the cap, answer ends on the last allowed byte,
        // trailing words arrive with nothing open
        put_header(16'h2468, 8'h80, 8'h00, 16'd2);
        put_question(NAME_PTR);
        filler = REPLY_CAP - reply_buf.size() - 12 - 16;
        put_record(NAME_PTR, 16'd16, 16'(filler));
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_reply(16'h2468, 16'd1, 1023, REPLY_CAP + 3);
    endtask

    task automatic test_restart();
        put_header(16'h7777, 8'h80, 8'h00, 16'd1);
        put_question(NAME_LABELS);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_reply(16'h7777, 16'd1, reply_buf.size(), 20);
        put_header(16'h8888, 8'h80, 8'h00, 16'd1);
        put_question(NAME_PTR);
        put_record(NAME_PTR, 16'd1, ADDR4_BYTES);
        send_reply(16'h8888, 16'd1, reply_buf.size(), 5);
        send_reply(16'h9999, 16'd1, 0, 0);
    endtask

    task automatic test_random_replies();
        int unsigned first_word, n, declared, count, nrec, r;
        logic [15:0] id, want, anc, rtype, rdlen;
        logic [3:0]  rc;
        first_word   = words_sent;
        idle_pct     = 0;
        while (words_sent - first_word < RANDOM_WORDS) begin
            if (words_sent - first_word >= CALM_WORDS)
                idle_pct = 16;
            if (chance(3))
                send_stray($urandom_range(1, 3));
            r = $urandom_range(0, 9);
            want = (r < 4) ? 16'd1 : (r < 8) ? TYPE_AAAA : 16'($urandom);
            r = $urandom_range(0, 99);
            rc = (r < 75) ? RCODE_NOERROR : (r < 83) ? RCODE_NXDOMAIN : 4'($urandom);
            anc = chance(5) ? 16'($urandom) : 16'($urandom_range(0, 3));
            nrec = chance(80) ? ((anc > 3) ? 3 : anc) : $urandom_range(0, 3);
            id = 16'($urandom);
            put_header(id, {chance(94), 7'($urandom)}, {4'($urandom), rc}, anc);
            put_question(name_style_t'($urandom_range(0, 2)));
            repeat (nrec) begin
                r = $urandom_range(0, 99);
                rtype = (r < 55) ? want : (r < 70) ? (chance(50) ? 16'd1 : TYPE_AAAA)
                                                   : 16'($urandom);
                if (rtype == want && chance(85))
                    rdlen = (want == TYPE_AAAA) ? ADDR6_BYTES : ADDR4_BYTES;
                else
                    rdlen = 16'($urandom_range(0, 20));
                put_record(name_style_t'($urandom_range(0, 2)), rtype, rdlen);
            end
            if (chance(20))
                put_random($urandom_range(1, 8));
            if (!chance(94))
                id = 16'($urandom);
            n = reply_buf.size();
            r = $urandom_range(0, 99);
            if (r < 85) begin
                declared = n;
                count    = n;
            end else if (r < 93) begin
                declared = $urandom_range(1, n - 1);
                count    = declared + $urandom_range(0, 2);
                if (count > n)
                    count = n;
            end else if (r < 97) begin
                declared = n + $urandom_range(1, 8);
                count    = declared;
            end else if (r < 99) begin
                // dropped by the next start word
                declared = n;
                count    = $urandom_range(0, n - 1);
            end else begin
                declared = $urandom_range(256, 1023);
                count    = (declared > REPLY_CAP + 2) ? REPLY_CAP + 2 : declared;
            end
            send_reply(id, want, declared, count);
        end
    endtask

    initial begin
        clear_reply();
        reply_len = 0;
        want_id   = '0;
        want_type = '0;
        ph        = P_IDLE;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_replies();
        test_header_checks();
        test_address_records();
        test_length_limits();
        test_restart();
        test_random_replies();

        s_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d words in %0d replies, %0d result words checked",
                 words_sent, replies_sent, results_seen);
        $display("outcomes: %0d resolved (%0d AAAA), %0d no data, %0d other rcode, %0d rejected",
                 status_seen[ST_RESOLVED], aaaa_seen, status_seen[ST_NO_DATA],
                 status_seen[ST_RCODE], status_seen[ST_REJECT]);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
